// ===== rtl/mesh_vertex_normal_accumulator_assert.svh =====
// Assertion macros used by the checker of this block.
`ifndef MESH_VERTEX_NORMAL_ACCUMULATOR_ASSERT_SVH
`define MESH_VERTEX_NORMAL_ACCUMULATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MVNA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MVNA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/mvna_pkg.sv =====
`default_nettype none
package mvna_pkg;

  localparam int VERTEX_SLOTS  = 1024;
  localparam int USE_COUNT_MAX = 255;
  localparam int SLOT_W        = $clog2(VERTEX_SLOTS);
  localparam int IDX_W         = 11;
  localparam int COORD_W       = 16;
  localparam int NORM_W        = 16;
  localparam int USES_W        = 8;
  localparam int CNT_W         = $clog2(USE_COUNT_MAX + 1);
  localparam int UNIT_ONE      = 16384;
  localparam int SUM_W         = $clog2(UNIT_ONE * USE_COUNT_MAX + 1) + 1;
  localparam int EDGE_W        = COORD_W + 1;
  localparam int PROD_W        = 2 * EDGE_W;
  localparam int CR_W          = PROD_W + 1;
  localparam int MAG_W         = PROD_W;
  localparam int MAGN_W        = 25;
  localparam int SQP_W         = 2 * MAGN_W;
  localparam int SQ_W          = SQP_W + 2;
  localparam int LEN_W         = SQ_W / 2;
  localparam int DIV_Q_W       = $clog2(UNIT_ONE) + 1;
  localparam int DIV_D_W       = LEN_W + 1;
  localparam int DIV_N_W       = DIV_D_W + DIV_Q_W - 1;

  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_FACE = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;

  typedef enum logic [1:0] {OP_LOAD, OP_FACE, OP_READ, OP_READ_NONE} cmd_op_t;

  typedef struct packed {
    logic [1:0]                mode;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic [IDX_W-1:0]          index_a;
    logic [IDX_W-1:0]          index_b;
    logic [IDX_W-1:0]          index_c;
  } in_item_t;

  typedef struct packed {
    logic signed [NORM_W-1:0] normal_x;
    logic signed [NORM_W-1:0] normal_y;
    logic signed [NORM_W-1:0] normal_z;
    logic [USES_W-1:0]        face_uses;
    logic                     unused_vertex;
    logic                     degenerate_seen;
  } out_item_t;

  typedef struct packed {
    cmd_op_t                   op;
    logic [SLOT_W-1:0]         slot_a;
    logic [SLOT_W-1:0]         slot_b;
    logic [SLOT_W-1:0]         slot_c;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } cmd_t;

  function automatic logic idx_ok(input logic [IDX_W-1:0] idx);
    return (idx != '0) && (32'(idx) <= 32'(VERTEX_SLOTS));
  endfunction

  function automatic logic [SLOT_W-1:0] slot_of(input logic [IDX_W-1:0] idx);
    return SLOT_W'(IDX_W'(idx - IDX_W'(1)));
  endfunction

endpackage
`default_nettype wire

// ===== rtl/mvna_front.sv =====
`default_nettype none
module mvna_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire mvna_pkg::in_item_t in_item,
  input  wire logic               clearing,
  output logic                    cmd_valid,
  input  wire logic               cmd_pop,
  output mvna_pkg::cmd_t          cmd
);

  mvna_pkg::cmd_t q_r [2];
  logic           wp_r;
  logic           rp_r;
  logic [1:0]     cnt_r;
  mvna_pkg::cmd_t cls;
  logic           keep;
  logic           ok_a;
  logic           ok_b;
  logic           ok_c;
  logic           push;
  logic           pop;

  always_comb begin
    ok_a = mvna_pkg::idx_ok(in_item.index_a);
    ok_b = mvna_pkg::idx_ok(in_item.index_b);
    ok_c = mvna_pkg::idx_ok(in_item.index_c);
    cls.slot_a = mvna_pkg::slot_of(in_item.index_a);
    cls.slot_b = mvna_pkg::slot_of(in_item.index_b);
    cls.slot_c = mvna_pkg::slot_of(in_item.index_c);
    cls.x = in_item.coord_x;
    cls.y = in_item.coord_y;
    cls.z = in_item.coord_z;
    unique case (in_item.mode)
      mvna_pkg::MODE_LOAD: begin
        cls.op = mvna_pkg::OP_LOAD;
        keep = ok_a;
      end
      mvna_pkg::MODE_FACE: begin
        cls.op = mvna_pkg::OP_FACE;
        keep = ok_a && ok_b && ok_c;
      end
      mvna_pkg::MODE_READ: begin
        cls.op = ok_a ? mvna_pkg::OP_READ : mvna_pkg::OP_READ_NONE;
        keep = 1'b1;
      end
      default: begin
        cls.op = mvna_pkg::OP_LOAD;
        keep = 1'b0;
      end
    endcase
  end

  assign in_full   = clearing || (cnt_r == 2'd2);
  assign push      = in_push && !in_full && keep;
  assign cmd_valid = (cnt_r != 2'd0);
  assign pop       = cmd_pop && cmd_valid;
  assign cmd       = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= cls;
  end

endmodule
`default_nettype wire

// ===== rtl/mvna_div.sv =====
`default_nettype none
module mvna_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [mvna_pkg::DIV_N_W-1:0] num,
  input  wire logic [mvna_pkg::DIV_D_W-1:0] den,
  output logic                              done,
  output logic [mvna_pkg::DIV_Q_W-1:0]      quo
);

  localparam int STEP_W = $clog2(mvna_pkg::DIV_Q_W);

  logic [mvna_pkg::DIV_N_W-1:0] rem_r;
  logic [mvna_pkg::DIV_N_W-1:0] dsh_r;
  logic [mvna_pkg::DIV_Q_W-1:0] quo_r;
  logic [STEP_W-1:0]            step_r;
  logic                         busy_r;
  logic                         done_r;

  assign done = done_r;
  assign quo  = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r  <= num;
        dsh_r  <= {den, {(mvna_pkg::DIV_Q_W - 1){1'b0}}};
        quo_r  <= '0;
        step_r <= STEP_W'(mvna_pkg::DIV_Q_W - 1);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (rem_r >= dsh_r) begin
          rem_r <= rem_r - dsh_r;
          quo_r <= {quo_r[mvna_pkg::DIV_Q_W-2:0], 1'b1};
        end else begin
          quo_r <= {quo_r[mvna_pkg::DIV_Q_W-2:0], 1'b0};
        end
        dsh_r  <= dsh_r >> 1;
        step_r <= step_r - STEP_W'(1);
        if (step_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/mvna_back.sv =====
`default_nettype none
module mvna_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cmd_valid,
  output logic                cmd_pop,
  input  wire mvna_pkg::cmd_t cmd,
  output logic                clearing,
  input  wire logic           cfg_we,
  input  wire logic [1:0]     cfg_sign,
  input  wire logic           res_full,
  output logic                res_push,
  output mvna_pkg::out_item_t res_item
);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_VB, S_VC, S_VD, S_MUL, S_MAG, S_NORM, S_SQ, S_SQI, S_SQRT,
    S_FDIV, S_FWAIT, S_ACC_RD, S_ACC_WR, S_RD, S_RDIV, S_RWAIT, S_OUT
  } state_t;

  typedef struct packed {
    logic signed [mvna_pkg::COORD_W-1:0] x;
    logic signed [mvna_pkg::COORD_W-1:0] y;
    logic signed [mvna_pkg::COORD_W-1:0] z;
  } vert_t;

  typedef struct packed {
    logic [mvna_pkg::CNT_W-1:0]        cnt;
    logic signed [mvna_pkg::SUM_W-1:0] sx;
    logic signed [mvna_pkg::SUM_W-1:0] sy;
    logic signed [mvna_pkg::SUM_W-1:0] sz;
  } acc_row_t;

  vert_t    vmem [mvna_pkg::VERTEX_SLOTS];
  acc_row_t amem [mvna_pkg::VERTEX_SLOTS];

  state_t                              state_r;
  logic [mvna_pkg::SLOT_W-1:0]         clr_r;
  mvna_pkg::cmd_t                      cmd_r;
  vert_t                               vrd_r;
  vert_t                               va_r;
  vert_t                               vb_r;
  acc_row_t                            ard_r;
  acc_row_t                            acc_r;
  logic signed [mvna_pkg::EDGE_W-1:0]  e1_r [3];
  logic signed [mvna_pkg::EDGE_W-1:0]  e2_r [3];
  logic [2:0]                          step_r;
  logic signed [mvna_pkg::PROD_W-1:0]  prod_r;
  logic signed [mvna_pkg::CR_W-1:0]    cr_r [3];
  logic                                neg_r [3];
  logic [mvna_pkg::MAG_W-1:0]          mag_r [3];
  logic [mvna_pkg::SQP_W-1:0]          sqp_r;
  logic [mvna_pkg::SQ_W-1:0]           sq_r;
  logic [mvna_pkg::SQ_W-1:0]           sqv_r;
  logic [mvna_pkg::SQ_W-1:0]           res_r;
  logic [mvna_pkg::SQ_W-1:0]           bit_r;
  logic [mvna_pkg::LEN_W-1:0]          len_r;
  logic [1:0]                          k_r;
  logic signed [mvna_pkg::NORM_W-1:0]  unit_r [3];
  mvna_pkg::out_item_t                 out_r;
  logic                                deg_r;
  logic [1:0]                          sign_r;

  logic                                vwe;
  logic [mvna_pkg::SLOT_W-1:0]         vwa;
  vert_t                               vwd;
  logic [mvna_pkg::SLOT_W-1:0]         vra;
  logic                                awe;
  logic [mvna_pkg::SLOT_W-1:0]         awa;
  acc_row_t                            awd;
  logic [mvna_pkg::SLOT_W-1:0]         ara;
  logic                                div_start;
  logic [mvna_pkg::DIV_N_W-1:0]        div_num;
  logic [mvna_pkg::DIV_D_W-1:0]        div_den;
  logic                                div_done;
  logic [mvna_pkg::DIV_Q_W-1:0]        div_quo;

  logic signed [mvna_pkg::EDGE_W-1:0]  ma;
  logic signed [mvna_pkg::EDGE_W-1:0]  mb;
  logic [2:0]                          prev;
  logic [1:0]                          pj;
  logic [mvna_pkg::MAG_W-1:0]          cabs [3];
  logic [mvna_pkg::MAG_W-1:0]          cmx;
  logic [mvna_pkg::MAG_W-1:0]          nmx;
  logic [mvna_pkg::MAGN_W-1:0]         sq_op;
  logic [mvna_pkg::MAGN_W-1:0]         mag_k;
  logic [mvna_pkg::SQ_W-1:0]           trial;
  logic [mvna_pkg::SQ_W-1:0]           res_new;
  logic [mvna_pkg::SLOT_W-1:0]         corner;
  logic signed [mvna_pkg::SUM_W-1:0]   acc_sum;
  logic [mvna_pkg::SUM_W-1:0]          rmag;
  logic signed [mvna_pkg::NORM_W-1:0]  rq;
  logic signed [mvna_pkg::NORM_W-1:0]  rval;
  logic signed [mvna_pkg::NORM_W-1:0]  uval;

  mvna_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (vwe) vmem[vwa] <= vwd;
    vrd_r <= vmem[vra];
  end

  always_ff @(posedge clk) begin
    if (awe) amem[awa] <= awd;
    ard_r <= amem[ara];
  end

  always_comb begin
    case (step_r)
      3'd0:    begin ma = e1_r[1]; mb = e2_r[2]; end
      3'd1:    begin ma = e1_r[2]; mb = e2_r[1]; end
      3'd2:    begin ma = e1_r[2]; mb = e2_r[0]; end
      3'd3:    begin ma = e1_r[0]; mb = e2_r[2]; end
      3'd4:    begin ma = e1_r[0]; mb = e2_r[1]; end
      3'd5:    begin ma = e1_r[1]; mb = e2_r[0]; end
      default: begin ma = '0; mb = '0; end
    endcase
    prev = step_r - 3'd1;
    pj   = prev[2:1];
    for (int k = 0; k < 3; k++) begin
      cabs[k] = cr_r[k][mvna_pkg::CR_W-1] ? mvna_pkg::MAG_W'(-cr_r[k])
                                           : mvna_pkg::MAG_W'(cr_r[k]);
    end
    cmx = cabs[0];
    if (cabs[1] > cmx) cmx = cabs[1];
    if (cabs[2] > cmx) cmx = cabs[2];
    nmx = mag_r[0];
    if (mag_r[1] > nmx) nmx = mag_r[1];
    if (mag_r[2] > nmx) nmx = mag_r[2];
    case (step_r)
      3'd0:    sq_op = mag_r[0][mvna_pkg::MAGN_W-1:0];
      3'd1:    sq_op = mag_r[1][mvna_pkg::MAGN_W-1:0];
      default: sq_op = mag_r[2][mvna_pkg::MAGN_W-1:0];
    endcase
    case (k_r)
      2'd0:    mag_k = mag_r[0][mvna_pkg::MAGN_W-1:0];
      2'd1:    mag_k = mag_r[1][mvna_pkg::MAGN_W-1:0];
      default: mag_k = mag_r[2][mvna_pkg::MAGN_W-1:0];
    endcase
    trial   = res_r + bit_r;
    res_new = (sqv_r >= trial) ? ((res_r >> 1) + bit_r) : (res_r >> 1);
    case (k_r)
      2'd0:    corner = cmd_r.slot_a;
      2'd1:    corner = cmd_r.slot_b;
      default: corner = cmd_r.slot_c;
    endcase
    case (k_r)
      2'd0:    acc_sum = acc_r.sx;
      2'd1:    acc_sum = acc_r.sy;
      default: acc_sum = acc_r.sz;
    endcase
    rmag = acc_sum[mvna_pkg::SUM_W-1] ? mvna_pkg::SUM_W'(-acc_sum)
                                       : mvna_pkg::SUM_W'(acc_sum);
    rq   = mvna_pkg::NORM_W'(div_quo);
    if (sign_r == 2'b00) begin
      rval = '0;
    end else if (acc_sum[mvna_pkg::SUM_W-1] ^ sign_r[1]) begin
      rval = -rq;
    end else begin
      rval = rq;
    end
    uval = neg_r[k_r] ? rq : -rq;
  end

  always_comb begin
    vwe       = 1'b0;
    vwa       = cmd.slot_a;
    vwd       = '{x: cmd.x, y: cmd.y, z: cmd.z};
    vra       = cmd.slot_a;
    awe       = 1'b0;
    awa       = clr_r;
    awd       = '0;
    ara       = cmd.slot_a;
    div_start = 1'b0;
    div_num   = mvna_pkg::DIV_N_W'({mag_k, {mvna_pkg::DIV_Q_W{1'b0}}})
                + mvna_pkg::DIV_N_W'(len_r);
    div_den   = mvna_pkg::DIV_D_W'({len_r, 1'b0});
    cmd_pop   = 1'b0;
    res_push  = 1'b0;
    unique case (state_r)
      S_CLEAR: awe = 1'b1;
      S_IDLE: begin
        cmd_pop = cmd_valid;
        if (cmd_valid && cmd.op == mvna_pkg::OP_LOAD) begin
          vwe = 1'b1;
          awe = 1'b1;
          awa = cmd.slot_a;
        end
      end
      S_VB: vra = cmd_r.slot_b;
      S_VC: vra = cmd_r.slot_c;
      S_FDIV: div_start = 1'b1;
      S_ACC_RD: ara = corner;
      S_ACC_WR: begin
        awa = corner;
        awe = (32'(ard_r.cnt) < 32'(mvna_pkg::USE_COUNT_MAX));
        awd.cnt = ard_r.cnt + mvna_pkg::CNT_W'(1);
        awd.sx  = ard_r.sx + mvna_pkg::SUM_W'(unit_r[0]);
        awd.sy  = ard_r.sy + mvna_pkg::SUM_W'(unit_r[1]);
        awd.sz  = ard_r.sz + mvna_pkg::SUM_W'(unit_r[2]);
      end
      S_RDIV: begin
        div_start = 1'b1;
        div_num = mvna_pkg::DIV_N_W'({rmag, 1'b0}) + mvna_pkg::DIV_N_W'(acc_r.cnt);
        div_den = mvna_pkg::DIV_D_W'({acc_r.cnt, 1'b0});
      end
      S_OUT: res_push = !res_full;
      default: ;
    endcase
  end

  assign clearing = (state_r == S_CLEAR);
  assign res_item = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      deg_r   <= 1'b0;
      sign_r  <= 2'b01;
    end else begin
      if (cfg_we) sign_r <= cfg_sign;
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + mvna_pkg::SLOT_W'(1);
          if (clr_r == mvna_pkg::SLOT_W'(mvna_pkg::VERTEX_SLOTS - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          cmd_r <= cmd;
          if (cmd_valid) begin
            unique case (cmd.op)
              mvna_pkg::OP_LOAD: state_r <= S_IDLE;
              mvna_pkg::OP_FACE: state_r <= S_VB;
              mvna_pkg::OP_READ: state_r <= S_RD;
              mvna_pkg::OP_READ_NONE: begin
                out_r   <= '{normal_x: '0, normal_y: '0, normal_z: '0, face_uses: '0,
                             unused_vertex: 1'b1, degenerate_seen: deg_r};
                state_r <= S_OUT;
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_VB: begin
          va_r    <= vrd_r;
          state_r <= S_VC;
        end
        S_VC: begin
          vb_r    <= vrd_r;
          state_r <= S_VD;
        end
        S_VD: begin
          e1_r[0] <= mvna_pkg::EDGE_W'(vb_r.x) - mvna_pkg::EDGE_W'(va_r.x);
          e1_r[1] <= mvna_pkg::EDGE_W'(vb_r.y) - mvna_pkg::EDGE_W'(va_r.y);
          e1_r[2] <= mvna_pkg::EDGE_W'(vb_r.z) - mvna_pkg::EDGE_W'(va_r.z);
          e2_r[0] <= mvna_pkg::EDGE_W'(vrd_r.x) - mvna_pkg::EDGE_W'(vb_r.x);
          e2_r[1] <= mvna_pkg::EDGE_W'(vrd_r.y) - mvna_pkg::EDGE_W'(vb_r.y);
          e2_r[2] <= mvna_pkg::EDGE_W'(vrd_r.z) - mvna_pkg::EDGE_W'(vb_r.z);
          for (int k = 0; k < 3; k++) cr_r[k] <= '0;
          step_r  <= 3'd0;
          state_r <= S_MUL;
        end
        S_MUL: begin
          prod_r <= mvna_pkg::PROD_W'(ma) * mvna_pkg::PROD_W'(mb);
          if (step_r != 3'd0) begin
            if (prev[0]) cr_r[pj] <= cr_r[pj] - mvna_pkg::CR_W'(prod_r);
            else         cr_r[pj] <= cr_r[pj] + mvna_pkg::CR_W'(prod_r);
          end
          step_r <= step_r + 3'd1;
          if (step_r == 3'd6) state_r <= S_MAG;
        end
        S_MAG: begin
          for (int k = 0; k < 3; k++) begin
            neg_r[k] <= cr_r[k][mvna_pkg::CR_W-1];
            mag_r[k] <= cabs[k];
          end
          if (cmx == '0) begin
            deg_r   <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            state_r <= S_NORM;
          end
        end
        S_NORM: begin
          if (nmx[mvna_pkg::MAG_W-1:mvna_pkg::MAGN_W] != '0) begin
            for (int k = 0; k < 3; k++) mag_r[k] <= mag_r[k] >> 1;
          end else if (!nmx[mvna_pkg::MAGN_W-1]) begin
            for (int k = 0; k < 3; k++) mag_r[k] <= mag_r[k] << 1;
          end else begin
            step_r  <= 3'd0;
            sq_r    <= '0;
            state_r <= S_SQ;
          end
        end
        S_SQ: begin
          sqp_r <= mvna_pkg::SQP_W'(sq_op) * mvna_pkg::SQP_W'(sq_op);
          if (step_r != 3'd0) sq_r <= sq_r + mvna_pkg::SQ_W'(sqp_r);
          step_r <= step_r + 3'd1;
          if (step_r == 3'd3) state_r <= S_SQI;
        end
        S_SQI: begin
          sqv_r   <= sq_r;
          res_r   <= '0;
          bit_r   <= mvna_pkg::SQ_W'(1) << (mvna_pkg::SQ_W - 2);
          state_r <= S_SQRT;
        end
        S_SQRT: begin
          if (sqv_r >= trial) sqv_r <= sqv_r - trial;
          res_r <= res_new;
          bit_r <= bit_r >> 2;
          if (bit_r[0]) begin
            len_r   <= mvna_pkg::LEN_W'(res_new);
            k_r     <= 2'd0;
            state_r <= S_FDIV;
          end
        end
        S_FDIV: state_r <= S_FWAIT;
        S_FWAIT: begin
          if (div_done) begin
            unit_r[k_r] <= uval;
            if (k_r == 2'd2) begin
              k_r     <= 2'd0;
              state_r <= S_ACC_RD;
            end else begin
              k_r     <= k_r + 2'd1;
              state_r <= S_FDIV;
            end
          end
        end
        S_ACC_RD: state_r <= S_ACC_WR;
        S_ACC_WR: begin
          if (k_r == 2'd2) begin
            state_r <= S_IDLE;
          end else begin
            k_r     <= k_r + 2'd1;
            state_r <= S_ACC_RD;
          end
        end
        S_RD: begin
          acc_r   <= ard_r;
          out_r   <= '{normal_x: '0, normal_y: '0, normal_z: '0,
                       face_uses: mvna_pkg::USES_W'(ard_r.cnt),
                       unused_vertex: (ard_r.cnt == '0), degenerate_seen: deg_r};
          k_r     <= 2'd0;
          state_r <= (ard_r.cnt == '0) ? S_OUT : S_RDIV;
        end
        S_RDIV: state_r <= S_RWAIT;
        S_RWAIT: begin
          if (div_done) begin
            case (k_r)
              2'd0:    out_r.normal_x <= rval;
              2'd1:    out_r.normal_y <= rval;
              default: out_r.normal_z <= rval;
            endcase
            if (k_r == 2'd2) begin
              state_r <= S_OUT;
            end else begin
              k_r     <= k_r + 2'd1;
              state_r <= S_RDIV;
            end
          end
        end
        S_OUT: begin
          if (!res_full) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/mvna_outq.sv =====
`default_nettype none
module mvna_outq (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                res_push,
  input  wire mvna_pkg::out_item_t res_item,
  output logic                     res_full,
  input  wire logic                out_pop,
  output logic                     out_empty,
  output mvna_pkg::out_item_t      out_item
);

  mvna_pkg::out_item_t q_r [2];
  logic                wp_r;
  logic                rp_r;
  logic [1:0]          cnt_r;
  logic                push;
  logic                pop;

  assign res_full  = (cnt_r == 2'd2);
  assign out_empty = (cnt_r == 2'd0);
  assign push      = res_push && !res_full;
  assign pop       = out_pop && !out_empty;
  assign out_item  = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= res_item;
  end

endmodule
`default_nettype wire

// ===== rtl/mesh_vertex_normal_accumulator.sv =====
// A load is handled in the idle state; a read divides each of its three sums by the use count.
// A face uses a cross-product multiplier, a separate squaring multiplier, a bit-serial square
// root and three passes of a radix-2 divider that reads also use.
// Items are processed one at a time; two commands and two results may wait in queues.
// Synchronous reset; afterwards a pass over all 1024 slots clears the sums and counts,
// during which in_full stays high. The configuration port is always ready.
`default_nettype none
module mesh_vertex_normal_accumulator (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_push,
  output logic                     in_full,
  input  wire mvna_pkg::in_item_t  in_item,
  output logic                     out_empty,
  input  wire logic                out_pop,
  output mvna_pkg::out_item_t      out_item,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [1:0]          cfg_data
);

  logic                cmd_valid;
  logic                cmd_pop;
  mvna_pkg::cmd_t      cmd;
  logic                clearing;
  logic                res_full;
  logic                res_push;
  mvna_pkg::out_item_t res_item;

  assign cfg_ready = 1'b1;

  mvna_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .clearing  (clearing),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd)
  );

  mvna_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .clearing  (clearing),
    .cfg_we    (cfg_valid),
    .cfg_sign  (cfg_data),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_item  (res_item)
  );

  mvna_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_push  (res_push),
    .res_item  (res_item),
    .res_full  (res_full),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

// ===== rtl/mvna_checker.sv =====
`default_nettype none
`include "mesh_vertex_normal_accumulator_assert.svh"
module mvna_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                out_empty,
  input wire logic                out_pop,
  input wire mvna_pkg::out_item_t out_item
);

  logic held;
  logic unused_head;
  logic unused_ok;
  logic used_head;
  logic flag_pop;
  logic flag_ok;

  assign held        = !out_empty && !out_pop;
  assign unused_head = !out_empty && out_item.unused_vertex;
  assign unused_ok   = (out_item.normal_x == '0) && (out_item.normal_y == '0) &&
                       (out_item.normal_z == '0) && (out_item.face_uses == '0);
  assign used_head   = !out_empty && !out_item.unused_vertex;
  assign flag_pop    = !out_empty && out_pop && out_item.degenerate_seen;
  assign flag_ok     = out_empty || out_item.degenerate_seen;

  `MVNA_ASSERT_NXT(a_head_held, clk, rst_n, held, !out_empty)
  `MVNA_ASSERT_NXT(a_head_stable, clk, rst_n, held, $stable(out_item))
  `MVNA_ASSERT_IMP(a_unused_zero, clk, rst_n, unused_head, unused_ok)
  `MVNA_ASSERT_IMP(a_used_count, clk, rst_n, used_head, out_item.face_uses != '0)
  `MVNA_ASSERT_NXT(a_flag_sticky, clk, rst_n, flag_pop, flag_ok)

endmodule

bind mesh_vertex_normal_accumulator mvna_checker u_checker (.*);
`default_nettype wire

// ===== tb/tb_mesh_vertex_normal_accumulator.sv =====
`default_nettype none
module tb_mesh_vertex_normal_accumulator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_NONE = 2'd3;
  localparam logic [1:0] SIGN_KEEP = 2'b01;
  localparam logic [1:0] SIGN_ZERO = 2'b00;
  localparam logic [1:0] SIGN_FLIP = 2'b11;
  localparam logic [1:0] SIGN_LOW  = 2'b10;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 500;

  typedef struct {
    mvna_pkg::in_item_t  it;
    bit                  typed;
    mvna_pkg::out_item_t want;
  } vector_t;

  logic                clk;
  logic                rst_n;
  logic                in_push;
  logic                in_full;
  mvna_pkg::in_item_t  in_item;
  logic                out_empty;
  logic                out_pop;
  mvna_pkg::out_item_t out_item;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [1:0]          cfg_data;

  mesh_vertex_normal_accumulator dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_item(in_item),
    .out_empty(out_empty), .out_pop(out_pop), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  logic signed [15:0] vert_x [mvna_pkg::VERTEX_SLOTS];
  logic signed [15:0] vert_y [mvna_pkg::VERTEX_SLOTS];
  logic signed [15:0] vert_z [mvna_pkg::VERTEX_SLOTS];
  longint sum_x [mvna_pkg::VERTEX_SLOTS];
  longint sum_y [mvna_pkg::VERTEX_SLOTS];
  longint sum_z [mvna_pkg::VERTEX_SLOTS];
  int     uses [mvna_pkg::VERTEX_SLOTS];
  bit     degenerate_seen;
  int     sign_factor;

  mvna_pkg::out_item_t pending_normals[$];
  int  fail_count;
  int  idle_cycles;
  bit  steady;
  bit  hold_go;
  int  pool[13];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic int slot_index(input logic [mvna_pkg::IDX_W-1:0] idx);
    if (idx == 0 || idx > mvna_pkg::VERTEX_SLOTS) return -1;
    return int'(idx) - 1;
  endfunction

  function automatic void add_face_normal(input int a, input int b, input int c);
    longint e1[3], e2[3], cr[3], unit[3];
    longint unsigned mag[3], mx, sq, len, q;
    bit neg[3];
    int corner[3];
    e1[0] = longint'(vert_x[b]) - longint'(vert_x[a]);
    e1[1] = longint'(vert_y[b]) - longint'(vert_y[a]);
    e1[2] = longint'(vert_z[b]) - longint'(vert_z[a]);
    e2[0] = longint'(vert_x[c]) - longint'(vert_x[b]);
    e2[1] = longint'(vert_y[c]) - longint'(vert_y[b]);
    e2[2] = longint'(vert_z[c]) - longint'(vert_z[b]);
    cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
    cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
    cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
    mx = 0;
    for (int k = 0; k < 3; k++) begin
      neg[k] = cr[k] < 0;
      mag[k] = neg[k] ? -cr[k] : cr[k];
      if (mag[k] > mx) mx = mag[k];
    end
    if (mx == 0) begin
      degenerate_seen = 1'b1;
      return;
    end
    while (mx >= (64'd1 << 25)) begin
      mx >>= 1;
      for (int k = 0; k < 3; k++) mag[k] >>= 1;
    end
    while (mx < (64'd1 << 24)) begin
      mx <<= 1;
      for (int k = 0; k < 3; k++) mag[k] <<= 1;
    end
    sq = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
    len = int_sqrt(sq);
    for (int k = 0; k < 3; k++) begin
      q = (mag[k] * 32768 + len) / (2 * len);
      unit[k] = neg[k] ? longint'(q) : -longint'(q);
    end
    corner[0] = a;
    corner[1] = b;
    corner[2] = c;
    for (int k = 0; k < 3; k++) begin
      if (uses[corner[k]] < mvna_pkg::USE_COUNT_MAX) begin
        sum_x[corner[k]] += unit[0];
        sum_y[corner[k]] += unit[1];
        sum_z[corner[k]] += unit[2];
        uses[corner[k]]++;
      end
    end
  endfunction

  function automatic logic [15:0] averaged(input longint s, input int cnt);
    longint unsigned m;
    longint q;
    m = (s < 0) ? -s : s;
    q = longint'((2 * m + cnt) / (2 * longint'(cnt)));
    if (s < 0) q = -q;
    return 16'(q * sign_factor);
  endfunction

  function automatic bit update_normals(input mvna_pkg::in_item_t it,
                                        output mvna_pkg::out_item_t res);
    int a, b, c, cnt;
    a = slot_index(it.index_a);
    b = slot_index(it.index_b);
    c = slot_index(it.index_c);
    res = '0;
    case (it.mode)
      mvna_pkg::MODE_LOAD: begin
        if (a >= 0) begin
          vert_x[a] = it.coord_x;
          vert_y[a] = it.coord_y;
          vert_z[a] = it.coord_z;
          sum_x[a] = 0;
          sum_y[a] = 0;
          sum_z[a] = 0;
          uses[a] = 0;
        end
        return 1'b0;
      end
      mvna_pkg::MODE_FACE: begin
        if (a >= 0 && b >= 0 && c >= 0) add_face_normal(a, b, c);
        return 1'b0;
      end
      mvna_pkg::MODE_READ: begin
        cnt = (a >= 0) ? uses[a] : 0;
        if (cnt != 0) begin
          res.normal_x = averaged(sum_x[a], cnt);
          res.normal_y = averaged(sum_y[a], cnt);
          res.normal_z = averaged(sum_z[a], cnt);
        end
        res.face_uses = mvna_pkg::USES_W'(cnt);
        res.unused_vertex = (cnt == 0);
        res.degenerate_seen = degenerate_seen;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic mvna_pkg::in_item_t mk(input logic [1:0] m, input int x, input int y,
                                            input int z, input int a, input int b,
                                            input int c);
    mvna_pkg::in_item_t it;
    it.mode = m;
    it.coord_x = 16'(x);
    it.coord_y = 16'(y);
    it.coord_z = 16'(z);
    it.index_a = mvna_pkg::IDX_W'(a);
    it.index_b = mvna_pkg::IDX_W'(b);
    it.index_c = mvna_pkg::IDX_W'(c);
    return it;
  endfunction

  task automatic send_item(input mvna_pkg::in_item_t it, input bit typed,
                           input mvna_pkg::out_item_t want);
    mvna_pkg::out_item_t res;
    if (!steady && $urandom_range(0, 99) < 15) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_push <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_full !== 1'b0) @(posedge clk);
    if (update_normals(it, res)) pending_normals.push_back(typed ? want : res);
    @(negedge clk);
  endtask

  task automatic send(input mvna_pkg::in_item_t it);
    send_item(it, 1'b0, '0);
  endtask

  task automatic write_sign(input logic [1:0] v);
    in_push <= 1'b0;
    while (pending_normals.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    sign_factor = $signed(v) < 0 ? -1 : int'($signed(v));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic int pick_pool();
    return pool[$urandom_range(0, 12)];
  endfunction

  function automatic int bad_index();
    return ($urandom_range(0, 3) == 0) ? 0
                                       : $urandom_range(mvna_pkg::VERTEX_SLOTS + 1, 2047);
  endfunction

  function automatic mvna_pkg::in_item_t random_item();
    int r, a, b, c;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      a = ($urandom_range(0, 99) < 80) ? pick_pool() : $urandom_range(0, 2047);
      return mk(mvna_pkg::MODE_LOAD, $urandom, $urandom, $urandom, a, $urandom, $urandom);
    end
    if (r < 62) begin
      a = pick_pool();
      b = pick_pool();
      c = pick_pool();
      r = $urandom_range(0, 99);
      if (r < 10) begin
        case ($urandom_range(0, 2))
          0: a = bad_index();
          1: b = bad_index();
          default: c = bad_index();
        endcase
      end else if (r < 18) begin
        c = a;
      end
      return mk(mvna_pkg::MODE_FACE, $urandom, $urandom, $urandom, a, b, c);
    end
    if (r < 92) begin
      a = ($urandom_range(0, 99) < 85) ? pick_pool() : $urandom_range(0, 2047);
      return mk(mvna_pkg::MODE_READ, $urandom, $urandom, $urandom, a, $urandom, $urandom);
    end
    return mk(MODE_NONE, $urandom, $urandom, $urandom, $urandom_range(0, 2047),
              $urandom_range(0, 2047), $urandom_range(0, 2047));
  endfunction

  task automatic random_phase(input int count);
    for (int i = 0; i < count; i++) send(random_item());
  endtask

  task automatic check_field(input string name, input longint e, input longint a);
    if (e != a) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, e, a);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    mvna_pkg::out_item_t e;
    if (rst_n && out_pop && out_empty === 1'b0) begin
      if (pending_normals.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %p", $time, out_item);
        fail_count++;
      end else begin
        e = pending_normals.pop_front();
        check_field("normal_x", e.normal_x, out_item.normal_x);
        check_field("normal_y", e.normal_y, out_item.normal_y);
        check_field("normal_z", e.normal_z, out_item.normal_z);
        check_field("face_uses", e.face_uses, out_item.face_uses);
        check_field("unused_vertex", e.unused_vertex, out_item.unused_vertex);
        check_field("degenerate_seen", e.degenerate_seen, out_item.degenerate_seen);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_push && in_full === 1'b0) || (out_pop && out_empty === 1'b0) ||
        (cfg_valid && cfg_ready === 1'b1)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("** mesh_vertex_normal_accumulator: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    out_pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go) begin
        out_pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_go = 1'b0;
      end else begin
        out_pop <= steady || ($urandom_range(0, 99) >= 15);
      end
    end
  end

  initial begin
    vector_t directed[$];
    mvna_pkg::out_item_t blank;
    rst_n = 1'b0;
    in_push = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    fail_count = 0;
    idle_cycles = 0;
    steady = 1'b0;
    hold_go = 1'b0;
    sign_factor = 1;
    degenerate_seen = 1'b0;
    for (int i = 0; i < mvna_pkg::VERTEX_SLOTS; i++) begin
      vert_x[i] = 0; vert_y[i] = 0; vert_z[i] = 0;
      sum_x[i] = 0; sum_y[i] = 0; sum_z[i] = 0;
      uses[i] = 0;
    end
    for (int i = 0; i < 12; i++) pool[i] = i + 1;
    pool[12] = mvna_pkg::VERTEX_SLOTS;

    blank = '0;
    blank.unused_vertex = 1'b1;
    directed.push_back('{mk(mvna_pkg::MODE_READ, 0, 0, 0, 1, 0, 0), 1'b1, blank});
    directed.push_back('{mk(mvna_pkg::MODE_READ, 0, 0, 0, 0, 0, 0), 1'b1, blank});
    directed.push_back('{mk(mvna_pkg::MODE_READ, -1, -1, -1, 2047, 2047, 2047), 1'b1, blank});
    directed.push_back('{mk(mvna_pkg::MODE_READ, 0, 0, 0, mvna_pkg::VERTEX_SLOTS + 1, 0, 0),
                         1'b1, blank});
    directed.push_back('{mk(mvna_pkg::MODE_LOAD, 0, 0, 0, 1, 0, 0), 1'b0, blank});
    directed.push_back('{mk(mvna_pkg::MODE_LOAD, 256, 0, 0, 2, 0, 0), 1'b0, blank});
    directed.push_back('{mk(mvna_pkg::MODE_LOAD, 0, 256, 0, 3, 0, 0), 1'b0, blank});
    directed.push_back('{mk(mvna_pkg::MODE_LOAD, 32767, -32768, 32767,
                            mvna_pkg::VERTEX_SLOTS, 0, 0), 1'b0, blank});
    directed.push_back('{mk(mvna_pkg::MODE_LOAD, -32768, 32767, -32768, 4, 0, 0),
                         1'b0, blank});
    directed.push_back('{mk(mvna_pkg::MODE_LOAD, 5, 5, 5, 0, 0, 0), 1'b0, blank});
    directed.push_back('{mk(mvna_pkg::MODE_LOAD, 5, 5, 5, 2047, 0, 0), 1'b0, blank});
    directed.push_back('{mk(mvna_pkg::MODE_FACE, 0, 0, 0, 1, 2, 3), 1'b0, blank});
    directed.push_back('{mk(mvna_pkg::MODE_FACE, 0, 0, 0, 0, 2, 3), 1'b0, blank});
    directed.push_back('{mk(mvna_pkg::MODE_FACE, 0, 0, 0, 1, 2, 2047), 1'b0, blank});
    directed.push_back('{mk(mvna_pkg::MODE_READ, 0, 0, 0, 2, 0, 0), 1'b0, blank});
    directed.push_back('{mk(mvna_pkg::MODE_FACE, 0, 0, 0, mvna_pkg::VERTEX_SLOTS, 4, 1),
                         1'b0, blank});
    directed.push_back('{mk(mvna_pkg::MODE_FACE, 0, 0, 0, 4, mvna_pkg::VERTEX_SLOTS, 2),
                         1'b0, blank});
    directed.push_back('{mk(mvna_pkg::MODE_FACE, 0, 0, 0, 1, 1, 2), 1'b0, blank});
    directed.push_back('{mk(MODE_NONE, -1, -1, -1, 1, 2, 3), 1'b0, blank});
    directed.push_back('{mk(mvna_pkg::MODE_READ, 0, 0, 0, 1, 0, 0), 1'b0, blank});
    directed.push_back('{mk(mvna_pkg::MODE_READ, 0, 0, 0, 3, 0, 0), 1'b0, blank});
    directed.push_back('{mk(mvna_pkg::MODE_READ, 0, 0, 0, 4, 0, 0), 1'b0, blank});
    directed.push_back('{mk(mvna_pkg::MODE_READ, 0, 0, 0, mvna_pkg::VERTEX_SLOTS, 0, 0),
                         1'b0, blank});
    directed.push_back('{mk(mvna_pkg::MODE_READ, 0, 0, 0, 9, 0, 0), 1'b0, blank});

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (directed[i]) send_item(directed[i].it, directed[i].typed, directed[i].want);

    for (int i = 0; i < 13; i++) begin
      send(mk(mvna_pkg::MODE_LOAD, $urandom_range(0, 4095) - 2048,
              $urandom_range(0, 4095) - 2048, $urandom_range(0, 4095) - 2048, pool[i], 0, 0));
    end
    hold_go = 1'b1;
    for (int i = 0; i < 12; i++) send(mk(mvna_pkg::MODE_READ, 0, 0, 0, pick_pool(), 0, 0));
    random_phase(40);

    write_sign(SIGN_FLIP);
    random_phase(30);

    write_sign(SIGN_ZERO);
    random_phase(10);
    steady = 1'b1;
    send(mk(mvna_pkg::MODE_LOAD, 0, 0, 0, 5, 0, 0));
    send(mk(mvna_pkg::MODE_LOAD, 512, 0, 0, 6, 0, 0));
    send(mk(mvna_pkg::MODE_LOAD, 0, 512, 0, 7, 0, 0));
    for (int i = 0; i < mvna_pkg::USE_COUNT_MAX + 5; i++) begin
      send(mk(mvna_pkg::MODE_FACE, 0, 0, 0, 5, 6, 7));
    end
    steady = 1'b0;
    write_sign(SIGN_LOW);
    for (int i = 5; i <= 7; i++) send(mk(mvna_pkg::MODE_READ, 0, 0, 0, i, 0, 0));
    random_phase(30);

    write_sign(SIGN_KEEP);
    for (int i = 5; i <= 7; i++) send(mk(mvna_pkg::MODE_READ, 0, 0, 0, i, 0, 0));
    random_phase(20);

    in_push <= 1'b0;
    while (pending_normals.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("** mesh_vertex_normal_accumulator: PASSED **");
    end else begin
      $display("** mesh_vertex_normal_accumulator: FAILED **");
    end
    $finish;
  end
endmodule
`default_nettype wire
